@@ hdl/llhc_pkg.sv @@
// Shared types and constants of the line length histogram classifier.
`timescale 1ns / 1ps

package llhc_pkg;

   localparam int NUM_BINS  = 4096;
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int LEN_W     = BIN_W + 1;
   localparam int LIM_W     = 12;
   localparam int CMP_W     = (BIN_W > LIM_W) ? BIN_W : LIM_W;
   localparam int IDX_W     = 12;
   localparam int CNT_W     = 32;
   localparam int SUM_W     = 48;
   localparam int CSR_IDX_W = 1;

   localparam logic [7:0] CHAR_LF = 8'd10;
   localparam logic [7:0] CHAR_CR = 8'd13;

   localparam logic [LIM_W-1:0] SHORT_LIMIT_RESET = LIM_W'(60);
   localparam logic [LIM_W-1:0] LONG_LIMIT_RESET  = LIM_W'(90);

   // Thresholds of the text classification.
   localparam logic [CNT_W-1:0] LONG_MIN      = CNT_W'(10);
   localparam logic [CNT_W-1:0] FEW_LONG_A    = CNT_W'(5);
   localparam logic [CNT_W-1:0] MANY_NORMAL_A = CNT_W'(50);
   localparam logic [CNT_W-1:0] FEW_LONG_B    = CNT_W'(10);
   localparam logic [CNT_W-1:0] MANY_NORMAL_B = CNT_W'(200);
   localparam logic [CNT_W-1:0] FEW_LONG_C    = CNT_W'(20);
   localparam logic [CNT_W-1:0] MANY_NORMAL_C = CNT_W'(500);

   typedef enum logic [1:0] {
      REQ_DATA  = 2'd0,
      REQ_EOF   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SHORT_LIMIT = 1'd0,
      CSR_LONG_LIMIT  = 1'd1
   } csr_index_type;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_BIN     = 1'b1
   } result_kind_type;

   typedef enum logic [2:0] {
      CLASS_EMPTY     = 3'd0,
      CLASS_SHORT     = 3'd1,
      CLASS_NORMAL    = 3'd2,
      CLASS_LONG      = 3'd3,
      CLASS_UNDEFINED = 3'd4
   } text_class_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_READOUT,
      ST_REPORT
   } state_type;

   // Events from the control into the statistics unit.
   typedef struct packed {
      logic             clear;
      logic             byte_seen;
      logic             close;
      logic [LEN_W-1:0] length;
   } stats_event_type;

   typedef struct packed {
      text_class_type   text_class;
      logic [BIN_W-1:0] longest_line;
      logic [CNT_W-1:0] lines_total;
      logic [CNT_W-1:0] bytes_total;
      logic [SUM_W-1:0] length_sum;
      logic [CNT_W-1:0] overlong_lines;
      logic [CNT_W-1:0] short_lines;
      logic [CNT_W-1:0] medium_lines;
      logic [CNT_W-1:0] long_lines;
   } summary_type;

   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] value);
      logic [LEN_W-1:0] result;
      result = value;
      if (value < LEN_W'(NUM_BINS)) begin
         result = value + LEN_W'(1);
      end
      return result;
   endfunction

endpackage

@@ hdl/llhc_hist_ram.sv @@
// Simple dual-port histogram memory with registered read data.
`timescale 1ns / 1ps

module llhc_hist_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/llhc_line_stats.sv @@
// Line statistics counters, band sorting and text classification.
`timescale 1ns / 1ps

module llhc_line_stats (
   input  logic                           clock,
   input  logic                           reset,
   input  llhc_pkg::stats_event_type      stats_event,
   input  logic [llhc_pkg::LIM_W-1:0]     short_limit,
   input  logic [llhc_pkg::LIM_W-1:0]     long_limit,
   output logic [llhc_pkg::BIN_W-1:0]     bin_addr,
   output llhc_pkg::summary_type          summary
);

   logic [llhc_pkg::BIN_W-1:0] max_seen_ff,  max_seen_in;
   logic [llhc_pkg::CNT_W-1:0] lines_ff,     lines_in;
   logic [llhc_pkg::CNT_W-1:0] bytes_ff,     bytes_in;
   logic [llhc_pkg::SUM_W-1:0] sum_ff,       sum_in;
   logic [llhc_pkg::CNT_W-1:0] overlong_ff,  overlong_in;
   logic [llhc_pkg::CNT_W-1:0] short_ff,     short_in;
   logic [llhc_pkg::CNT_W-1:0] medium_ff,    medium_in;
   logic [llhc_pkg::CNT_W-1:0] long_ff,      long_in;

   logic                       overlong;
   logic [llhc_pkg::BIN_W-1:0] clamped;
   logic [llhc_pkg::CMP_W-1:0] clamped_cmp;
   llhc_pkg::text_class_type   text_class;

   // A length of NUM_BINS sets the top bit of the length and lands in the top bin.
   assign overlong    = stats_event.length[llhc_pkg::BIN_W];
   assign clamped     = overlong ? llhc_pkg::BIN_W'(llhc_pkg::NUM_BINS - 1)
                                 : stats_event.length[llhc_pkg::BIN_W-1:0];
   assign clamped_cmp = llhc_pkg::CMP_W'(clamped);
   assign bin_addr    = clamped;

   always_comb begin
      max_seen_in = max_seen_ff;
      lines_in    = lines_ff;
      bytes_in    = bytes_ff;
      sum_in      = sum_ff;
      overlong_in = overlong_ff;
      short_in    = short_ff;
      medium_in   = medium_ff;
      long_in     = long_ff;
      if (stats_event.byte_seen) begin
         bytes_in = bytes_ff + llhc_pkg::CNT_W'(1);
      end
      if (stats_event.close) begin
         lines_in = lines_ff + llhc_pkg::CNT_W'(1);
         sum_in   = sum_ff + llhc_pkg::SUM_W'(clamped);
         if (overlong) begin
            overlong_in = overlong_ff + llhc_pkg::CNT_W'(1);
         end
         if (clamped > max_seen_ff) begin
            max_seen_in = clamped;
         end
         priority if (clamped_cmp < llhc_pkg::CMP_W'(short_limit)) begin
            short_in = short_ff + llhc_pkg::CNT_W'(1);
         end else if (clamped_cmp >= llhc_pkg::CMP_W'(long_limit)) begin
            long_in = long_ff + llhc_pkg::CNT_W'(1);
         end else begin
            medium_in = medium_ff + llhc_pkg::CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || stats_event.clear) begin
         max_seen_ff <= '0;
         lines_ff    <= '0;
         bytes_ff    <= '0;
         sum_ff      <= '0;
         overlong_ff <= '0;
         short_ff    <= '0;
         medium_ff   <= '0;
         long_ff     <= '0;
      end else begin
         max_seen_ff <= max_seen_in;
         lines_ff    <= lines_in;
         bytes_ff    <= bytes_in;
         sum_ff      <= sum_in;
         overlong_ff <= overlong_in;
         short_ff    <= short_in;
         medium_ff   <= medium_in;
         long_ff     <= long_in;
      end
   end

   // The long-line test compares against twice the medium count, so one extra bit.
   always_comb begin
      priority if ((medium_ff == '0) && (long_ff == '0)) begin
         text_class = (short_ff != '0) ? llhc_pkg::CLASS_SHORT : llhc_pkg::CLASS_EMPTY;
      end else if (long_ff == '0) begin
         text_class = llhc_pkg::CLASS_NORMAL;
      end else if ((long_ff >= llhc_pkg::LONG_MIN) &&
                   ({1'b0, long_ff} >= {medium_ff, 1'b0})) begin
         text_class = llhc_pkg::CLASS_LONG;
      end else if (((long_ff <= llhc_pkg::FEW_LONG_A) && (medium_ff >= llhc_pkg::MANY_NORMAL_A)) ||
                   ((long_ff <= llhc_pkg::FEW_LONG_B) && (medium_ff >= llhc_pkg::MANY_NORMAL_B)) ||
                   ((long_ff <= llhc_pkg::FEW_LONG_C) && (medium_ff >= llhc_pkg::MANY_NORMAL_C)))
      begin
         text_class = llhc_pkg::CLASS_NORMAL;
      end else begin
         text_class = llhc_pkg::CLASS_UNDEFINED;
      end
   end

   assign summary.text_class     = text_class;
   assign summary.longest_line   = max_seen_ff;
   assign summary.lines_total    = lines_ff;
   assign summary.bytes_total    = bytes_ff;
   assign summary.length_sum     = sum_ff;
   assign summary.overlong_lines = overlong_ff;
   assign summary.short_lines    = short_ff;
   assign summary.medium_lines   = medium_ff;
   assign summary.long_lines     = long_ff;

endmodule

@@ hdl/line_length_histogram_classifier.sv @@
// Top level: request control, histogram memory update and result register.
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Transaction
// req      in         req_valid/req_stall  data byte, end of file, bin read, start
// rsp      out        rsp_valid/rsp_stall  end of file summary or bin readout
// csr      in         csr_write            limit register write, no read-back
//
// A byte that does not end a line stays in idle; one that ends a line also passes
// the update state, since the histogram bin is read and then written back through
// the memory. End of file passes update only if a line is open, then report; a bin
// read passes readout. After reset and after each start request the histogram
// memory is cleared one entry a cycle; no request is taken until it is all clear.
// A pending result waits in the output register; data bytes still flow meanwhile.

module line_length_histogram_classifier (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_type,
   input  logic [7:0]                       req_data_byte,
   input  logic [llhc_pkg::IDX_W-1:0]       req_bin_index,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic [2:0]                       rsp_text_class,
   output logic [11:0]                      rsp_longest_line,
   output logic [31:0]                      rsp_lines_total,
   output logic [31:0]                      rsp_bytes_total,
   output logic [47:0]                      rsp_length_sum,
   output logic [31:0]                      rsp_overlong_lines,
   output logic [31:0]                      rsp_short_lines,
   output logic [31:0]                      rsp_medium_lines,
   output logic [31:0]                      rsp_long_lines,
   output logic [31:0]                      rsp_bin_count,

   input  logic                             csr_write,
   input  logic [llhc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [llhc_pkg::LIM_W-1:0]       csr_wdata
);

   llhc_pkg::state_type            state_ff, state_in;
   logic [llhc_pkg::LEN_W-1:0]     cur_len_ff, cur_len_in;
   logic                           cr_ff, cr_in;
   logic                           eof_pend_ff, eof_pend_in;
   logic [llhc_pkg::BIN_W-1:0]     upd_addr_ff, upd_addr_in;
   logic [llhc_pkg::BIN_W-1:0]     clr_addr_ff, clr_addr_in;
   logic                           in_range_ff, in_range_in;
   logic [llhc_pkg::LIM_W-1:0]     short_limit_ff, long_limit_ff;

   logic                           rsp_valid_ff;
   llhc_pkg::result_kind_type      rsp_kind_ff;
   llhc_pkg::summary_type          rsp_summary_ff;
   logic [llhc_pkg::CNT_W-1:0]     rsp_bin_ff;

   llhc_pkg::stats_event_type      stats_event;
   llhc_pkg::summary_type          summary;
   logic [llhc_pkg::BIN_W-1:0]     bin_addr;
   llhc_pkg::req_kind_type         req_kind;
   logic [llhc_pkg::LEN_W-1:0]     len_cr;
   logic                           req_accept;
   logic                           load_bin;
   logic                           load_summary;

   logic                           wr_en;
   logic [llhc_pkg::BIN_W-1:0]     wr_addr;
   logic [llhc_pkg::CNT_W-1:0]     wr_data;
   logic                           rd_en;
   logic [llhc_pkg::BIN_W-1:0]     rd_addr;
   logic [llhc_pkg::CNT_W-1:0]     rd_data;

   assign req_kind = llhc_pkg::req_kind_type'(req_type);

   // Requests that produce a result wait until the output register is free.
   assign req_stall  = (state_ff != llhc_pkg::ST_IDLE) ||
                       (rsp_valid_ff && ((req_kind == llhc_pkg::REQ_EOF) ||
                                         (req_kind == llhc_pkg::REQ_READ)));
   assign req_accept = req_valid && !req_stall;

   // A held CR that is not followed by LF counts as one character.
   assign len_cr = cr_ff ? llhc_pkg::sat_inc(cur_len_ff) : cur_len_ff;

   always_comb begin
      state_in     = state_ff;
      cur_len_in   = cur_len_ff;
      cr_in        = cr_ff;
      eof_pend_in  = eof_pend_ff;
      upd_addr_in  = upd_addr_ff;
      clr_addr_in  = clr_addr_ff;
      in_range_in  = in_range_ff;
      stats_event  = '0;
      wr_en        = 1'b0;
      wr_addr      = upd_addr_ff;
      wr_data      = rd_data + llhc_pkg::CNT_W'(1);
      rd_en        = 1'b0;
      rd_addr      = bin_addr;
      load_bin     = 1'b0;
      load_summary = 1'b0;
      unique case (state_ff)
         llhc_pkg::ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_data     = '0;
            clr_addr_in = clr_addr_ff + llhc_pkg::BIN_W'(1);
            if (clr_addr_ff == llhc_pkg::BIN_W'(llhc_pkg::NUM_BINS - 1)) begin
               state_in = llhc_pkg::ST_IDLE;
            end
         end
         llhc_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_kind)
                  llhc_pkg::REQ_DATA: begin
                     stats_event.byte_seen = 1'b1;
                     if (req_data_byte == llhc_pkg::CHAR_LF) begin
                        stats_event.close  = 1'b1;
                        stats_event.length = cur_len_ff;
                        cur_len_in  = '0;
                        cr_in       = 1'b0;
                        rd_en       = 1'b1;
                        upd_addr_in = bin_addr;
                        state_in    = llhc_pkg::ST_UPDATE;
                     end else if (req_data_byte == llhc_pkg::CHAR_CR) begin
                        cur_len_in = len_cr;
                        cr_in      = 1'b1;
                     end else begin
                        cur_len_in = llhc_pkg::sat_inc(len_cr);
                        cr_in      = 1'b0;
                     end
                  end
                  llhc_pkg::REQ_EOF: begin
                     cr_in = 1'b0;
                     if (len_cr != '0) begin
                        stats_event.close  = 1'b1;
                        stats_event.length = len_cr;
                        cur_len_in  = '0;
                        rd_en       = 1'b1;
                        upd_addr_in = bin_addr;
                        eof_pend_in = 1'b1;
                        state_in    = llhc_pkg::ST_UPDATE;
                     end else begin
                        state_in = llhc_pkg::ST_REPORT;
                     end
                  end
                  llhc_pkg::REQ_READ: begin
                     rd_en       = 1'b1;
                     rd_addr     = llhc_pkg::BIN_W'(req_bin_index);
                     in_range_in = (32'(req_bin_index) < 32'(llhc_pkg::NUM_BINS));
                     state_in    = llhc_pkg::ST_READOUT;
                  end
                  llhc_pkg::REQ_CLEAR: begin
                     stats_event.clear = 1'b1;
                     cur_len_in  = '0;
                     cr_in       = 1'b0;
                     clr_addr_in = '0;
                     state_in    = llhc_pkg::ST_CLEAR;
                  end
                  default: begin
                     state_in = llhc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         llhc_pkg::ST_UPDATE: begin
            wr_en       = 1'b1;
            eof_pend_in = 1'b0;
            state_in    = eof_pend_ff ? llhc_pkg::ST_REPORT : llhc_pkg::ST_IDLE;
         end
         llhc_pkg::ST_READOUT: begin
            load_bin = 1'b1;
            state_in = llhc_pkg::ST_IDLE;
         end
         llhc_pkg::ST_REPORT: begin
            load_summary = 1'b1;
            state_in     = llhc_pkg::ST_IDLE;
         end
         default: begin
            state_in = llhc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= llhc_pkg::ST_CLEAR;
         cur_len_ff  <= '0;
         cr_ff       <= 1'b0;
         eof_pend_ff <= 1'b0;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         cur_len_ff  <= cur_len_in;
         cr_ff       <= cr_in;
         eof_pend_ff <= eof_pend_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      upd_addr_ff <= upd_addr_in;
      in_range_ff <= in_range_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_limit_ff <= llhc_pkg::SHORT_LIMIT_RESET;
         long_limit_ff  <= llhc_pkg::LONG_LIMIT_RESET;
      end else if (csr_write) begin
         unique case (llhc_pkg::csr_index_type'(csr_index))
            llhc_pkg::CSR_SHORT_LIMIT: short_limit_ff <= csr_wdata;
            llhc_pkg::CSR_LONG_LIMIT:  long_limit_ff  <= csr_wdata;
            default: begin
               short_limit_ff <= short_limit_ff;
            end
         endcase
      end
   end

   // Output register; the unused fields of each result kind read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_bin || load_summary) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_bin) begin
         rsp_kind_ff    <= llhc_pkg::KIND_BIN;
         rsp_summary_ff <= '0;
         rsp_bin_ff     <= in_range_ff ? rd_data : '0;
      end else if (load_summary) begin
         rsp_kind_ff    <= llhc_pkg::KIND_SUMMARY;
         rsp_summary_ff <= summary;
         rsp_bin_ff     <= '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_text_class     = rsp_summary_ff.text_class;
   assign rsp_longest_line   = 12'(rsp_summary_ff.longest_line);
   assign rsp_lines_total    = rsp_summary_ff.lines_total;
   assign rsp_bytes_total    = rsp_summary_ff.bytes_total;
   assign rsp_length_sum     = rsp_summary_ff.length_sum;
   assign rsp_overlong_lines = rsp_summary_ff.overlong_lines;
   assign rsp_short_lines    = rsp_summary_ff.short_lines;
   assign rsp_medium_lines   = rsp_summary_ff.medium_lines;
   assign rsp_long_lines     = rsp_summary_ff.long_lines;
   assign rsp_bin_count      = rsp_bin_ff;

   llhc_line_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .stats_event (stats_event),
      .short_limit (short_limit_ff),
      .long_limit  (long_limit_ff),
      .bin_addr    (bin_addr),
      .summary     (summary)
   );

   llhc_hist_ram #(
      .DEPTH (llhc_pkg::NUM_BINS),
      .WIDTH (llhc_pkg::CNT_W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule
